### sv/rfe_pkg.sv
// ----------------------------------------------------------------------------
// RGB fade engine package
// Shared widths, operation codes, sequencer states and control bundles.
// ----------------------------------------------------------------------------
package rfe_pkg;

   // Default configuration of the engine.
   localparam int SLOTS_DEF = 8;
   localparam int FRAC_DEF  = 16;

   // Fixed field widths.
   localparam int COLOR_W = 8;
   localparam int SLOT_W  = 3;
   localparam int DUR_W   = 12;
   localparam int DT_W    = 8;

   // Operation codes carried by an item.
   typedef enum logic [1:0] {
      FUNC_FADE   = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_SET    = 2'd3
   } func_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SLOT,
      ST_RD,
      ST_SET_WR,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FADE_WR,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ADV_SUM,
      ST_ADV_WR,
      ST_NEAR,
      ST_SNAP_RD,
      ST_SNAP_WR,
      ST_CAN_WR,
      ST_FLAGS,
      ST_EMIT_RD,
      ST_EMIT_CAP,
      ST_EMIT_OUT
   } state_type;

   // Write strobes into the color store.
   typedef struct packed {
      logic cur_we;
      logic fade_we;
   } store_ctl_type;

   // Command to the shared multiply/divide unit.
   typedef struct packed {
      logic start;
      logic div;
   } mdu_ctl_type;

endpackage

### sv/rgb_fade_engine_pingpong_unit.sv
// ----------------------------------------------------------------------------
// RGB fade engine with ping-pong
// Color slots fading linearly in fixed point between a start and an end
// color, driven by start, tick, cancel and set-color items.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (valid/ready). Start fade and set color address
//   one slot and return one result item; tick and cancel walk every slot and
//   return one result item per slot, slot 0 first, rsp_last on the final one.
//   Start fade and set color on a slot number of SLOTS or above return nothing.
// Timing:
//   One item is worked at a time; req_ready is low until its last result
//   item sits in the output register. A sequencer drives a single shared
//   bit-serial multiply/divide unit and a single store port. Per channel a
//   fade start runs a division (one divide step per cycle) and a tick a
//   multiplication (12 multiply steps); reading a slot out for its result
//   goes through the store one channel after another.
// Reset and stalls:
//   Synchronous reset clears all colors to zero and stops all fades; no
//   clearing pass is needed. A stalled result holds the output register and
//   the engine waits before loading the next slot's result.
// ----------------------------------------------------------------------------
module rgb_fade_engine_pingpong_unit #(
   parameter int SLOTS     = rfe_pkg::SLOTS_DEF,
   parameter int FRAC_BITS = rfe_pkg::FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [rfe_pkg::SLOT_W-1:0]    req_slot,
   input  logic [rfe_pkg::COLOR_W-1:0]   req_red,
   input  logic [rfe_pkg::COLOR_W-1:0]   req_green,
   input  logic [rfe_pkg::COLOR_W-1:0]   req_blue,
   input  logic [rfe_pkg::DUR_W-1:0]     req_duration,
   input  logic                          req_bounce,
   input  logic [rfe_pkg::DT_W-1:0]      req_elapsed,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfe_pkg::SLOT_W-1:0]    rsp_out_slot,
   output logic [rfe_pkg::COLOR_W-1:0]   rsp_out_red,
   output logic [rfe_pkg::COLOR_W-1:0]   rsp_out_green,
   output logic [rfe_pkg::COLOR_W-1:0]   rsp_out_blue,
   output logic                          rsp_fading,
   output logic                          rsp_last
);
   import rfe_pkg::*;

   localparam int CW = COLOR_W + FRAC_BITS;
   localparam int PW = CW + DUR_W;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   store_ctl_type      st_ctl;
   logic [SW+1:0]      st_addr;
   logic [CW-1:0]      st_cur_wdata;
   logic [CW-1:0]      st_end_wdata;
   logic signed [CW:0] st_step_wdata;
   logic [CW-1:0]      cur_q, start_q, end_q;
   logic signed [CW:0] step_q;

   mdu_ctl_type        mdu_ctl;
   logic [CW-1:0]      mdu_a;
   logic [DUR_W-1:0]   mdu_b;
   logic               mdu_busy;
   logic [CW-1:0]      mdu_quo;
   logic [PW-1:0]      mdu_prod;

   // Sequencer, flags and output register.
   rfe_seq #(
      .SLOTS     (SLOTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_slot      (req_slot),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_duration  (req_duration),
      .req_bounce    (req_bounce),
      .req_elapsed   (req_elapsed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_slot  (rsp_out_slot),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_fading    (rsp_fading),
      .rsp_last      (rsp_last),
      .st_ctl        (st_ctl),
      .st_addr       (st_addr),
      .st_cur_wdata  (st_cur_wdata),
      .st_end_wdata  (st_end_wdata),
      .st_step_wdata (st_step_wdata),
      .cur_q         (cur_q),
      .start_q       (start_q),
      .end_q         (end_q),
      .step_q        (step_q),
      .mdu_ctl       (mdu_ctl),
      .mdu_a         (mdu_a),
      .mdu_b         (mdu_b),
      .mdu_busy      (mdu_busy),
      .mdu_quo       (mdu_quo),
      .mdu_prod      (mdu_prod)
   );

   // Color and fade parameter storage. A fade start records the current
   // color as its start point.
   rfe_store #(
      .SLOTS     (SLOTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (st_ctl),
      .addr        (st_addr),
      .cur_wdata   (st_cur_wdata),
      .start_wdata (cur_q),
      .end_wdata   (st_end_wdata),
      .step_wdata  (st_step_wdata),
      .cur_q       (cur_q),
      .start_q     (start_q),
      .end_q       (end_q),
      .step_q      (step_q)
   );

   // Shared bit-serial multiply/divide unit.
   rfe_mdu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mdu (
      .clock (clock),
      .reset (reset),
      .ctl   (mdu_ctl),
      .op_a  (mdu_a),
      .op_b  (mdu_b),
      .busy  (mdu_busy),
      .quo   (mdu_quo),
      .prod  (mdu_prod)
   );

   // A result item that is not the last of its run means the run is still
   // in progress, so no new item may be taken.
   a_no_accept_mid_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("input accepted while a run still has results to deliver");

   // The shared unit is never restarted while it is still iterating.
   a_mdu_no_restart : assert property (@(posedge clock) disable iff (reset)
      mdu_ctl.start |-> !mdu_busy)
      else $error("multiply/divide unit started while busy");

   // Whenever the engine is ready for an item, the shared unit is idle.
   a_ready_mdu_idle : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mdu_busy)
      else $error("engine ready while multiply/divide unit is busy");

   // A started operation keeps the unit busy in the following cycle.
   a_mdu_runs : assert property (@(posedge clock) disable iff (reset)
      mdu_ctl.start |=> mdu_busy)
      else $error("multiply/divide unit did not start");

endmodule

### sv/rfe_mdu.sv
// ----------------------------------------------------------------------------
// RGB fade engine multiply/divide unit
// One shared adder, used one bit per cycle for restoring division
// (quotient of a channel difference by a duration) or for shift-add
// multiplication (step magnitude times elapsed ticks).
// ----------------------------------------------------------------------------
module rfe_mdu #(
   parameter int FRAC_BITS = rfe_pkg::FRAC_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  rfe_pkg::mdu_ctl_type                            ctl,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]           op_a,
   input  logic [rfe_pkg::DUR_W-1:0]                       op_b,
   output logic                                            busy,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]           quo,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS+rfe_pkg::DUR_W-1:0] prod
);
   import rfe_pkg::*;

   localparam int CW    = COLOR_W + FRAC_BITS;
   localparam int PW    = CW + DUR_W;
   localparam int CNT_W = $clog2(CW + 1);

   logic             busy_ff, busy_in;
   logic             div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    a_ff, a_in;
   logic [DUR_W-1:0] b_ff, b_in;
   logic [DUR_W-1:0] rem_ff, rem_in;
   logic [PW-1:0]    acc_ff, acc_in;

   logic [PW-1:0]    add_x, add_y, add_sum;
   logic             add_c;
   logic             trial_ok;

   // Shared adder: trial subtract for division, accumulate for multiply.
   always_comb begin
      if (div_ff) begin
         add_x = PW'({rem_ff, a_ff[CW-1]});
         add_y = ~PW'(b_ff);
         add_c = 1'b1;
      end else begin
         add_x = {acc_ff[PW-2:0], 1'b0};
         add_y = b_ff[DUR_W-1] ? PW'(a_ff) : '0;
         add_c = 1'b0;
      end
   end

   assign add_sum  = add_x + add_y + PW'(add_c);
   assign trial_ok = ~add_sum[PW-1];

   // One iteration per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.div;
         cnt_in  = ctl.div ? CNT_W'(CW) : CNT_W'(DUR_W);
         a_in    = op_a;
         b_in    = op_b;
         rem_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
         if (div_ff) begin
            rem_in = trial_ok ? add_sum[DUR_W-1:0] : {rem_ff[DUR_W-2:0], a_ff[CW-1]};
            a_in   = {a_ff[CW-2:0], trial_ok};
         end else begin
            acc_in = add_sum;
            b_in   = {b_ff[DUR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign quo  = a_ff;
   assign prod = acc_ff;

endmodule

### sv/rfe_store.sv
// ----------------------------------------------------------------------------
// RGB fade engine color store
// Per slot and channel: current color, fade start, fade end and step.
// One address per cycle, registered read data. The current color has a
// valid bit per entry so that it reads as zero until first written.
// ----------------------------------------------------------------------------
module rfe_store #(
   parameter int SLOTS     = rfe_pkg::SLOTS_DEF,
   parameter int FRAC_BITS = rfe_pkg::FRAC_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  rfe_pkg::store_ctl_type                      ctl,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)+1:0] addr,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       cur_wdata,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       start_wdata,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       end_wdata,
   input  logic signed [rfe_pkg::COLOR_W+FRAC_BITS:0]  step_wdata,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       cur_q,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       start_q,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       end_q,
   output logic signed [rfe_pkg::COLOR_W+FRAC_BITS:0]  step_q
);
   import rfe_pkg::*;

   localparam int CW    = COLOR_W + FRAC_BITS;
   localparam int DEPTH = SLOTS * 4;

   logic [CW-1:0]        cur_mem   [DEPTH];
   logic [CW-1:0]        start_mem [DEPTH];
   logic [CW-1:0]        end_mem   [DEPTH];
   logic signed [CW:0]   step_mem  [DEPTH];
   logic [DEPTH-1:0]     vld_ff;

   logic [CW-1:0]        cur_rd_ff;
   logic                 rd_vld_ff;
   logic [CW-1:0]        start_rd_ff;
   logic [CW-1:0]        end_rd_ff;
   logic signed [CW:0]   step_rd_ff;

   // Current color memory with its valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.cur_we) begin
         vld_ff[addr] <= 1'b1;
      end
      if (ctl.cur_we) begin
         cur_mem[addr] <= cur_wdata;
      end
      cur_rd_ff <= cur_mem[addr];
      rd_vld_ff <= vld_ff[addr];
   end

   // Fade parameter memories, written together by a fade start.
   always_ff @(posedge clock) begin
      if (ctl.fade_we) begin
         start_mem[addr] <= start_wdata;
         end_mem[addr]   <= end_wdata;
         step_mem[addr]  <= step_wdata;
      end
      start_rd_ff <= start_mem[addr];
      end_rd_ff   <= end_mem[addr];
      step_rd_ff  <= step_mem[addr];
   end

   assign cur_q   = rd_vld_ff ? cur_rd_ff : '0;
   assign start_q = start_rd_ff;
   assign end_q   = end_rd_ff;
   assign step_q  = step_rd_ff;

endmodule

### sv/rfe_seq.sv
// ----------------------------------------------------------------------------
// RGB fade engine sequencer
// Walks slots and channels for each item, drives the store and the shared
// multiply/divide unit, keeps the per-slot fade flags and owns the result
// output register.
// ----------------------------------------------------------------------------
module rfe_seq #(
   parameter int SLOTS     = rfe_pkg::SLOTS_DEF,
   parameter int FRAC_BITS = rfe_pkg::FRAC_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Input item channel.
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [1:0]                                  req_func,
   input  logic [rfe_pkg::SLOT_W-1:0]                  req_slot,
   input  logic [rfe_pkg::COLOR_W-1:0]                 req_red,
   input  logic [rfe_pkg::COLOR_W-1:0]                 req_green,
   input  logic [rfe_pkg::COLOR_W-1:0]                 req_blue,
   input  logic [rfe_pkg::DUR_W-1:0]                   req_duration,
   input  logic                                        req_bounce,
   input  logic [rfe_pkg::DT_W-1:0]                    req_elapsed,
   // Result channel.
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [rfe_pkg::SLOT_W-1:0]                  rsp_out_slot,
   output logic [rfe_pkg::COLOR_W-1:0]                 rsp_out_red,
   output logic [rfe_pkg::COLOR_W-1:0]                 rsp_out_green,
   output logic [rfe_pkg::COLOR_W-1:0]                 rsp_out_blue,
   output logic                                        rsp_fading,
   output logic                                        rsp_last,
   // Color store.
   output rfe_pkg::store_ctl_type                      st_ctl,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)+1:0] st_addr,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       st_cur_wdata,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       st_end_wdata,
   output logic signed [rfe_pkg::COLOR_W+FRAC_BITS:0]  st_step_wdata,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       cur_q,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       start_q,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       end_q,
   input  logic signed [rfe_pkg::COLOR_W+FRAC_BITS:0]  step_q,
   // Multiply/divide unit.
   output rfe_pkg::mdu_ctl_type                        mdu_ctl,
   output logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       mdu_a,
   output logic [rfe_pkg::DUR_W-1:0]                   mdu_b,
   input  logic                                        mdu_busy,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS-1:0]       mdu_quo,
   input  logic [rfe_pkg::COLOR_W+FRAC_BITS+rfe_pkg::DUR_W-1:0] mdu_prod
);
   import rfe_pkg::*;

   localparam int CW    = COLOR_W + FRAC_BITS;
   localparam int PW    = CW + DUR_W;
   localparam int SUM_W = PW + 2;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
   localparam logic [1:0]    LAST_CH  = 2'd2;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   logic [SW-1:0]                 idx_ff, idx_in;
   logic [1:0]                    ch_ff, ch_in;
   logic [2:0][COLOR_W-1:0]       col_ff, col_in;
   logic [DUR_W-1:0]              dur_ff, dur_in;
   logic                          bounce_ff, bounce_in;
   logic [DT_W-1:0]               dt_ff, dt_in;
   logic [SLOTS-1:0]              active_ff, active_in;
   logic [SLOTS-1:0]              forward_ff, forward_in;
   logic [SLOTS-1:0]              repeat_ff, repeat_in;
   logic                          near_ff, near_in;
   logic                          diff_neg_ff, diff_neg_in;
   logic                          diff_nz_ff, diff_nz_in;
   logic [CW-1:0]                 dist_ff, dist_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [CW-1:0]                 new_ff, new_in;
   logic [2:0][COLOR_W-1:0]       emit_ff, emit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]             rsp_slot_ff, rsp_slot_in;
   logic [2:0][COLOR_W-1:0]       rsp_col_ff, rsp_col_in;
   logic                          rsp_fading_ff, rsp_fading_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [CW-1:0]      col_fix;
   logic [CW-1:0]      tgt;
   logic signed [CW:0] diff_s;
   logic [CW-1:0]      diff_mag;
   logic [CW-1:0]      q_adj;
   logic signed [CW:0] step_new;
   logic [CW-1:0]      step_abs;
   logic signed [CW:0] dist_s;
   logic [CW-1:0]      dist_mag;
   logic               dir_neg;
   logic [SUM_W-1:0]   cur_wide;
   logic [SUM_W-1:0]   md_wide;
   logic [CW-1:0]      clamp_v;
   logic               move_ok;
   logic signed [CW:0] ndist_s;
   logic [CW-1:0]      ndist_mag;
   logic               near_ch;
   logic               slot_ok;
   logic               is_last;
   logic               out_free;

   // Written color in channel fixed point, and the current fade target.
   assign col_fix = {col_ff[ch_ff], {FRAC_BITS{1'b0}}};
   assign tgt     = forward_ff[idx_ff] ? end_q : start_q;

   // Fade start: difference to the new end color and its per-tick step.
   assign diff_s   = $signed({1'b0, col_fix}) - $signed({1'b0, cur_q});
   assign diff_mag = diff_s[CW] ? CW'(-diff_s) : diff_s[CW-1:0];
   assign q_adj    = (mdu_quo == '0 && diff_nz_ff) ? CW'(1) : mdu_quo;
   assign step_new = diff_neg_ff ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});

   // Tick: distance to target and the moved value.
   assign step_abs = step_q[CW] ? CW'(-step_q) : step_q[CW-1:0];
   assign dist_s   = $signed({1'b0, cur_q}) - $signed({1'b0, tgt});
   assign dist_mag = dist_s[CW] ? CW'(-dist_s) : dist_s[CW-1:0];
   assign dir_neg  = step_q[CW] ^ ~forward_ff[idx_ff];
   assign cur_wide = SUM_W'(cur_q);
   assign md_wide  = SUM_W'(mdu_prod);
   assign move_ok  = PW'(dist_ff) >= mdu_prod;

   // Saturate the moved value to the channel range.
   assign clamp_v = sum_ff[SUM_W-1]          ? '0 :
                    (|sum_ff[SUM_W-2:CW])    ? '1 : sum_ff[CW-1:0];

   // Near test on the updated channel value.
   assign ndist_s   = $signed({1'b0, new_ff}) - $signed({1'b0, tgt});
   assign ndist_mag = ndist_s[CW] ? CW'(-ndist_s) : ndist_s[CW-1:0];
   assign near_ch   = PW'(ndist_mag) <= mdu_prod;

   assign slot_ok  = 32'(req_slot) < SLOTS;
   assign is_last  = (func_ff == FUNC_FADE) || (func_ff == FUNC_SET) || (idx_ff == LAST_IDX);
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Store address and write data.
   assign st_addr       = {idx_ff, ch_ff};
   assign st_end_wdata  = col_fix;
   assign st_step_wdata = step_new;

   always_comb begin
      unique case (state_ff)
         ST_SET_WR:  st_cur_wdata = col_fix;
         ST_ADV_WR:  st_cur_wdata = clamp_v;
         ST_SNAP_WR: st_cur_wdata = tgt;
         default:    st_cur_wdata = start_q;
      endcase
   end

   // Next state and control.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      ch_in         = ch_ff;
      col_in        = col_ff;
      dur_in        = dur_ff;
      bounce_in     = bounce_ff;
      dt_in         = dt_ff;
      active_in     = active_ff;
      forward_in    = forward_ff;
      repeat_in     = repeat_ff;
      near_in       = near_ff;
      diff_neg_in   = diff_neg_ff;
      diff_nz_in    = diff_nz_ff;
      dist_in       = dist_ff;
      sum_in        = sum_ff;
      new_in        = new_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_fading_in = rsp_fading_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      st_ctl        = '0;
      mdu_ctl       = '0;
      mdu_a         = diff_mag;
      mdu_b         = dur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in   = func_type'(req_func);
               col_in    = {req_blue, req_green, req_red};
               dur_in    = (req_duration == '0) ? DUR_W'(1) : req_duration;
               bounce_in = req_bounce;
               dt_in     = req_elapsed;
               ch_in     = '0;
               unique case (func_type'(req_func))
                  FUNC_FADE: begin
                     idx_in = SW'(req_slot);
                     if (slot_ok) begin
                        state_in = ST_RD;
                     end
                  end
                  FUNC_SET: begin
                     idx_in = SW'(req_slot);
                     if (slot_ok) begin
                        state_in = ST_SET_WR;
                     end
                  end
                  default: begin
                     idx_in   = '0;
                     state_in = ST_SLOT;
                  end
               endcase
            end
         end

         // Skip slots without a running fade.
         ST_SLOT: begin
            ch_in   = '0;
            near_in = 1'b1;
            state_in = active_ff[idx_ff] ? ST_RD : ST_EMIT_RD;
         end

         ST_RD: begin
            unique case (func_ff)
               FUNC_FADE:   state_in = ST_DIV_GO;
               FUNC_TICK:   state_in = ST_MUL_GO;
               FUNC_CANCEL: state_in = ST_CAN_WR;
               default:     state_in = ST_SET_WR;
            endcase
         end

         ST_SET_WR: begin
            st_ctl.cur_we = 1'b1;
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = ST_EMIT_RD;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end

         // Step = difference / duration, by the shared divider.
         ST_DIV_GO: begin
            mdu_ctl.start = 1'b1;
            mdu_ctl.div   = 1'b1;
            diff_neg_in   = diff_s[CW];
            diff_nz_in    = diff_s != '0;
            state_in      = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (!mdu_busy) begin
               state_in = ST_FADE_WR;
            end
         end

         ST_FADE_WR: begin
            st_ctl.fade_we = 1'b1;
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = ST_FLAGS;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_RD;
            end
         end

         // Delta magnitude = |step| * elapsed, by the shared multiplier.
         ST_MUL_GO: begin
            mdu_ctl.start = 1'b1;
            mdu_a         = step_abs;
            mdu_b         = DUR_W'(dt_ff);
            state_in      = ST_MUL_WAIT;
         end

         ST_MUL_WAIT: begin
            if (!mdu_busy) begin
               state_in = ST_ADV_SUM;
            end
         end

         ST_ADV_SUM: begin
            dist_in  = dist_mag;
            sum_in   = dir_neg ? cur_wide - md_wide : cur_wide + md_wide;
            state_in = ST_ADV_WR;
         end

         // A channel moves only while a full delta away from the target.
         ST_ADV_WR: begin
            if (move_ok) begin
               st_ctl.cur_we = 1'b1;
               new_in        = clamp_v;
            end else begin
               new_in = cur_q;
            end
            state_in = ST_NEAR;
         end

         ST_NEAR: begin
            near_in = near_ff & near_ch;
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = (near_ff & near_ch) ? ST_SNAP_RD : ST_EMIT_RD;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_RD;
            end
         end

         ST_SNAP_RD: begin
            state_in = ST_SNAP_WR;
         end

         ST_SNAP_WR: begin
            st_ctl.cur_we = 1'b1;
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = ST_FLAGS;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_SNAP_RD;
            end
         end

         ST_CAN_WR: begin
            st_ctl.cur_we = 1'b1;
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = ST_FLAGS;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_RD;
            end
         end

         // Per-slot flag update at the end of the slot's work.
         ST_FLAGS: begin
            unique case (func_ff)
               FUNC_FADE: begin
                  active_in[idx_ff]  = 1'b1;
                  forward_in[idx_ff] = 1'b1;
                  repeat_in[idx_ff]  = bounce_ff;
               end
               FUNC_TICK: begin
                  if (repeat_ff[idx_ff]) begin
                     forward_in[idx_ff] = ~forward_ff[idx_ff];
                  end else begin
                     active_in[idx_ff] = 1'b0;
                  end
               end
               default: begin
                  active_in[idx_ff]  = 1'b0;
                  forward_in[idx_ff] = 1'b1;
               end
            endcase
            state_in = ST_EMIT_RD;
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_CAP;
         end

         ST_EMIT_CAP: begin
            emit_in[ch_ff] = cur_q[CW-1 -: COLOR_W];
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = ST_EMIT_OUT;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_EMIT_RD;
            end
         end

         // Hand the slot's item to the output register once it is free.
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = SLOT_W'(idx_ff);
               rsp_col_in    = emit_ff;
               rsp_fading_in = active_ff[idx_ff];
               rsp_last_in   = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + SW'(1);
                  state_in = ST_SLOT;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         forward_ff   <= '1;
         repeat_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         forward_ff   <= forward_in;
         repeat_ff    <= repeat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      ch_ff         <= ch_in;
      col_ff        <= col_in;
      dur_ff        <= dur_in;
      bounce_ff     <= bounce_in;
      dt_ff         <= dt_in;
      near_ff       <= near_in;
      diff_neg_ff   <= diff_neg_in;
      diff_nz_ff    <= diff_nz_in;
      dist_ff       <= dist_in;
      sum_ff        <= sum_in;
      new_ff        <= new_in;
      emit_ff       <= emit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_fading_ff <= rsp_fading_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_slot  = rsp_slot_ff;
   assign rsp_out_red   = rsp_col_ff[0];
   assign rsp_out_green = rsp_col_ff[1];
   assign rsp_out_blue  = rsp_col_ff[2];
   assign rsp_fading    = rsp_fading_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
